// ===== hw/rtl/vwd_pkg.sv =====
`timescale 1ns / 1ps
package vwd_pkg;
    localparam int MaxVertices = 4096;
    localparam int HashSlots   = 8192;
    localparam int IdxW  = $clog2(MaxVertices);
    localparam int CntW  = IdxW + 1;
    localparam int SlotW = $clog2(HashSlots);
    localparam int SlotCntW = SlotW + 1;
    localparam int KeyW  = 96;
    localparam int EpochW = 8;
    localparam int SlotDataW = EpochW + KeyW + IdxW;

    localparam logic REQ_WELD  = 1'b0;
    localparam logic REQ_REMAP = 1'b1;

    function automatic logic [31:0] mix_in(input logic [31:0] seed, input logic [31:0] v);
        mix_in = seed ^ (v + 32'h9e3779b9 + (seed << 6) + (seed >> 2));
    endfunction
endpackage

// ===== hw/rtl/vwd_ram.sv =====
`timescale 1ns / 1ps
module vwd_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/vertex_weld_dedup.sv =====
`timescale 1ns / 1ps
// weld: S_HASH, S_READ and S_CMP lie between accept and result strobe when the first probed
// slot decides, with S_READ and S_CMP again for every further slot probed; remap: S_MAP alone
// one item in flight at a time, busy high until the result beat; results cannot be stalled
// reset (i_rst_n low, synchronous) clears counts, then sweeps all 8192 slots (busy high)
// restart is free except every 255th, which sweeps all slots again before the item
module vertex_weld_dedup
    import vwd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            i_req_type,
    input  logic [31:0]     i_pos_x,
    input  logic [31:0]     i_pos_y,
    input  logic [31:0]     i_pos_z,
    input  logic [IdxW-1:0] i_vertex_index,
    input  logic            i_restart,
    output logic            o_valid,
    output logic [IdxW-1:0] o_mapped_index,
    output logic            o_is_new,
    output logic            o_found,
    output logic            o_overflow
);
    typedef enum logic [2:0] {S_IDLE, S_HASH, S_READ, S_CMP, S_MAP, S_SWEEP} t_state;

    t_state r_state;
    logic r_init;
    logic r_req;
    logic [KeyW-1:0] r_key;
    logic [IdxW-1:0] r_vi;
    logic [SlotW-1:0] r_slot;
    logic [SlotCntW-1:0] r_probes;
    logic [CntW-1:0] r_ucnt, r_vcnt;
    logic [EpochW-1:0] r_epoch;
    logic [SlotW-1:0] r_sweep;
    logic [31:0] r_h;

    logic s_we;
    logic [SlotW-1:0] s_waddr;
    logic [SlotDataW-1:0] s_wdata, s_rdata;
    logic m_we;
    logic [IdxW-1:0] m_waddr, m_wdata, m_raddr, m_rdata;

    vwd_ram #(.Width(SlotDataW), .Depth(HashSlots)) u_slots (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(r_slot), .o_rdata(s_rdata)
    );
    vwd_ram #(.Width(IdxW), .Depth(MaxVertices)) u_map (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    logic [EpochW-1:0] slot_ep;
    logic [KeyW-1:0] slot_key;
    logic [IdxW-1:0] slot_idx;
    logic slot_live, slot_hit, do_new;
    assign {slot_ep, slot_key, slot_idx} = s_rdata;
    // epoch zero is only ever written by a sweep, never live
    assign slot_live = (slot_ep == r_epoch);
    assign slot_hit = slot_live && (slot_key == r_key);
    assign do_new = !slot_live && (r_ucnt < CntW'(MaxVertices));

    assign busy = (r_state != S_IDLE);
    assign m_raddr = (r_state == S_IDLE) ? i_vertex_index : r_vi;

    always_comb begin
        s_we = 1'b0;
        s_waddr = r_slot;
        s_wdata = {r_epoch, r_key, r_ucnt[IdxW-1:0]};
        m_we = 1'b0;
        m_waddr = r_vcnt[IdxW-1:0];
        m_wdata = slot_hit ? slot_idx : r_ucnt[IdxW-1:0];
        if (r_state == S_SWEEP) begin
            s_we = 1'b1;
            s_waddr = r_sweep;
            s_wdata = '0;
        end else if (r_state == S_CMP && (slot_hit || do_new)) begin
            s_we = do_new;
            m_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_ucnt <= '0;
            r_vcnt <= '0;
            r_epoch <= EpochW'(1);
            r_init <= 1'b0;
            r_sweep <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req <= i_req_type;
                        r_key <= {i_pos_x, i_pos_y, i_pos_z};
                        r_vi <= i_vertex_index;
                        r_h <= mix_in(32'd0, i_pos_x);
                        r_probes <= '0;
                        if (i_restart) begin
                            r_ucnt <= '0;
                            r_vcnt <= '0;
                            if (r_epoch == '1) begin
                                r_epoch <= EpochW'(1);
                            end else begin
                                r_epoch <= r_epoch + 1'b1;
                            end
                        end
                        if (i_restart && r_epoch == '1) begin
                            r_sweep <= '0;
                            r_state <= S_SWEEP;
                        end else begin
                            r_state <= (i_req_type == REQ_REMAP) ? S_MAP : S_HASH;
                        end
                    end
                end
                S_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == SlotW'(HashSlots - 1)) begin
                        if (!r_init) begin
                            r_init <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= (r_req == REQ_REMAP) ? S_MAP : S_HASH;
                        end
                    end
                end
                S_MAP: begin
                    o_valid <= 1'b1;
                    o_is_new <= 1'b0;
                    o_overflow <= 1'b0;
                    if (CntW'(r_vi) < r_vcnt) begin
                        o_found <= 1'b1;
                        o_mapped_index <= m_rdata;
                    end else begin
                        o_found <= 1'b0;
                        o_mapped_index <= r_vi;
                    end
                    r_state <= S_IDLE;
                end
                S_HASH: begin
                    if (r_vcnt >= CntW'(MaxVertices)) begin
                        o_valid <= 1'b1;
                        o_overflow <= 1'b1;
                        o_mapped_index <= '0;
                        o_is_new <= 1'b0;
                        o_found <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_slot <= SlotW'(mix_in(mix_in(r_h, r_key[63:32]), r_key[31:0]));
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_CMP;
                S_CMP: begin
                    if (slot_hit || !slot_live ||
                        r_probes == SlotCntW'(HashSlots - 1)) begin
                        o_valid <= 1'b1;
                        o_found <= 1'b0;
                        o_is_new <= do_new;
                        o_overflow <= !(slot_hit || do_new);
                        o_mapped_index <= slot_hit ? slot_idx :
                                          (do_new ? r_ucnt[IdxW-1:0] : '0);
                        if (do_new) r_ucnt <= r_ucnt + 1'b1;
                        if (slot_hit || do_new) r_vcnt <= r_vcnt + 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                        r_probes <= r_probes + 1'b1;
                        r_state <= S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ucnt_le_vcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ucnt <= r_vcnt) else $error("unique count above vertex count");
    a_new_not_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_new && o_overflow)) else $error("new and overflow");
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_valid) |-> !busy || $past(start)) else $error("busy after result");
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import vwd_pkg::*;

    typedef struct packed {
        logic [IdxW-1:0] mapped;
        logic            is_new;
        logic            found;
        logic            overflow;
    } t_weld_result;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    logic            i_req_type = REQ_WELD;
    logic [31:0]     i_pos_x = '0;
    logic [31:0]     i_pos_y = '0;
    logic [31:0]     i_pos_z = '0;
    logic [IdxW-1:0] i_vertex_index = '0;
    logic            i_restart = 1'b0;
    logic            o_valid;
    logic [IdxW-1:0] o_mapped_index;
    logic            o_is_new;
    logic            o_found;
    logic            o_overflow;

    vertex_weld_dedup dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    int              uniq_cnt;
    int              vert_cnt;
    logic [IdxW-1:0] weld_map [MaxVertices];
    int              uniq_of [logic [95:0]];
    t_weld_result    pending_results [$];
    int              errors = 0;
    int              idle_cycles = 0;
    bit              quiet = 0;
    logic [95:0]     pool [64];

    function automatic t_weld_result predict_weld(logic req, logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z, logic [IdxW-1:0] idx,
                                                  logic rst);
        t_weld_result r;
        logic [95:0] key;
        r = '0;
        key = {x, y, z};
        if (rst) begin
            uniq_of.delete();
            uniq_cnt = 0;
            vert_cnt = 0;
        end
        if (req == REQ_REMAP) begin
            if (idx < vert_cnt) begin
                r.mapped = weld_map[idx];
                r.found = 1'b1;
            end else begin
                r.mapped = idx;
            end
        end else if (vert_cnt >= MaxVertices) begin
            r.overflow = 1'b1;
        end else begin
            if (uniq_of.exists(key)) begin
                r.mapped = uniq_of[key][IdxW-1:0];
            end else if (uniq_cnt < MaxVertices) begin
                uniq_of[key] = uniq_cnt;
                r.mapped = uniq_cnt[IdxW-1:0];
                r.is_new = 1'b1;
                uniq_cnt++;
            end else begin
                r.overflow = 1'b1;
            end
            if (!r.overflow) begin
                weld_map[vert_cnt] = r.mapped;
                vert_cnt++;
            end
        end
        return r;
    endfunction

    task automatic send(logic req, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                        logic [IdxW-1:0] idx, logic rst, bit has_exp, t_weld_result exp_r);
        t_weld_result r;
        if (!quiet && $urandom_range(99) < 14) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= req;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        i_vertex_index <= idx;
        i_restart <= rst;
        do @(posedge i_clk); while (busy);
        r = predict_weld(req, x, y, z, idx, rst);
        pending_results.insert(pending_results.size(), has_exp ? exp_r : r);
    endtask

    task automatic weld(logic [95:0] key, logic rst);
        send(REQ_WELD, key[95:64], key[63:32], key[31:0], IdxW'($urandom), rst, 0, '0);
    endtask

    task automatic remap(logic [IdxW-1:0] idx, logic rst);
        send(REQ_REMAP, $urandom, $urandom, $urandom, idx, rst, 0, '0);
    endtask

    task automatic random_beat(bit allow_restart);
        int sel;
        logic [95:0] key;
        sel = $urandom_range(99);
        if (sel < 30) begin
            if ($urandom_range(9) == 0) remap(IdxW'($urandom), 0);
            else remap(IdxW'($urandom_range(vert_cnt + 4)), 0);
        end else begin
            if (sel < 70) key = pool[$urandom_range(63)];
            else key = {$urandom, $urandom, $urandom};
            weld(key, allow_restart && $urandom_range(49) == 0);
        end
    endtask

    // result check and watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 40000) begin
            $display("FAIL vertex_weld_dedup");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected beat: mapped_index %0d", o_mapped_index);
                errors++;
            end else begin
                t_weld_result e;
                e = pending_results.pop_front();
                if (o_mapped_index !== e.mapped) begin
                    $error("mapped_index exp %0d got %0d", e.mapped, o_mapped_index);
                    errors++;
                end
                if (o_is_new !== e.is_new) begin
                    $error("is_new exp %0d got %0d", e.is_new, o_is_new);
                    errors++;
                end
                if (o_found !== e.found) begin
                    $error("found exp %0d got %0d", e.found, o_found);
                    errors++;
                end
                if (o_overflow !== e.overflow) begin
                    $error("overflow exp %0d got %0d", e.overflow, o_overflow);
                    errors++;
                end
            end
        end
    end

    typedef struct {
        logic            req;
        logic [95:0]     key;
        logic [IdxW-1:0] idx;
        logic            rst;
        bit              has_exp;
        t_weld_result    exp_r;
    } t_stim_row;

    t_stim_row directed [] = '{
        '{REQ_REMAP, 96'h0, 12'd0, 1'b0, 1, '{12'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_REMAP, 96'h0, 12'd4095, 1'b0, 1, '{12'd4095, 1'b0, 1'b0, 1'b0}},
        '{REQ_WELD, 96'h0, 12'd0, 1'b0, 1, '{12'd0, 1'b1, 1'b0, 1'b0}},
        '{REQ_WELD, {32'h80000000, 64'h0}, 12'd0, 1'b0, 1, '{12'd1, 1'b1, 1'b0, 1'b0}},
        '{REQ_WELD, 96'h0, 12'd4095, 1'b0, 1, '{12'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_WELD, {96{1'b1}}, 12'd0, 1'b0, 1, '{12'd2, 1'b1, 1'b0, 1'b0}},
        '{REQ_WELD, {3{32'h7fc00000}}, 12'd0, 1'b0, 0, '0},
        '{REQ_WELD, {3{32'h7fc00000}}, 12'd0, 1'b0, 0, '0},
        '{REQ_WELD, {64'h0, 32'h80000000}, 12'd0, 1'b0, 0, '0},
        '{REQ_WELD, {32'h80000000, 64'h0}, 12'd0, 1'b0, 0, '0},
        '{REQ_REMAP, 96'h0, 12'd0, 1'b0, 0, '0},
        '{REQ_REMAP, 96'h0, 12'd1, 1'b0, 0, '0},
        '{REQ_REMAP, 96'h0, 12'd5, 1'b0, 0, '0},
        '{REQ_REMAP, 96'h0, 12'd7, 1'b0, 0, '0},
        '{REQ_REMAP, 96'h0, 12'd8, 1'b0, 0, '0},
        '{REQ_WELD, {32'h3f800000, 32'h40000000, 32'h40400000}, 12'd0, 1'b1, 1,
          '{12'd0, 1'b1, 1'b0, 1'b0}},
        '{REQ_REMAP, 96'h0, 12'd0, 1'b1, 1, '{12'd0, 1'b0, 1'b0, 1'b0}},
        '{REQ_WELD, 96'h0, 12'd0, 1'b0, 1, '{12'd0, 1'b1, 1'b0, 1'b0}},
        '{REQ_REMAP, 96'h0, 12'd0, 1'b0, 0, '0}
    };

    initial begin
        for (int i = 0; i < 64; i++) begin
            if (i < 4) pool[i] = {(i[0] ? 32'h80000000 : 32'h0), 32'h0,
                                  (i[1] ? 32'h80000000 : 32'h0)};
            else pool[i] = {$urandom, $urandom, $urandom};
        end
        uniq_cnt = 0;
        vert_cnt = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            send(directed[i].req, directed[i].key[95:64], directed[i].key[63:32],
                 directed[i].key[31:0], directed[i].idx, directed[i].rst,
                 directed[i].has_exp, directed[i].exp_r);
        end

        for (int n = 0; n < 1600; n++) begin
            quiet = (n >= 500 && n < 800);
            random_beat(1);
        end

        remap(12'd4095, 0);
        weld(pool[0], 1);

        start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0) $display("PASS vertex_weld_dedup");
        else $display("FAIL vertex_weld_dedup");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/vwd_pkg.sv
hw/rtl/vwd_ram.sv
hw/rtl/vertex_weld_dedup.sv
verif/testbench.sv
